@@ rtl/core/mwrf_pkg.sv @@
// Package: shared constants, types and the CRC byte update for the Modbus register framer.
package mwrf_pkg;

    localparam int VOLTAGE_FRACTION_BITS = 8;
    localparam int ADDR_W     = 16;
    localparam int VOLT_W     = 24;
    localparam int VAL_W      = 16;
    localparam int BYTE_W     = 8;
    localparam int SCALE_W    = 7;
    localparam int PROD_W     = VOLT_W + SCALE_W;
    localparam int IN_W       = ADDR_W + VOLT_W;
    localparam int NSTAGE     = 7;
    localparam int FRAME_LEN  = 8;
    localparam int IDX_W      = $clog2(FRAME_LEN);

    localparam logic [BYTE_W-1:0]  FUNC_WRITE_SINGLE = 8'h06;
    localparam logic [15:0]        CRC_POLY          = 16'hA001;
    localparam logic [15:0]        CRC_INIT          = 16'hFFFF;
    localparam logic [SCALE_W-1:0] SCALE_HUNDREDTHS  = 7'd100;
    localparam logic [BYTE_W-1:0]  SLAVE_ADDR_RESET  = 8'd1;

    localparam logic [IDX_W-1:0] BYTE_SLAVE   = 3'd0;
    localparam logic [IDX_W-1:0] BYTE_FUNC    = 3'd1;
    localparam logic [IDX_W-1:0] BYTE_ADDR_HI = 3'd2;
    localparam logic [IDX_W-1:0] BYTE_ADDR_LO = 3'd3;
    localparam logic [IDX_W-1:0] BYTE_VAL_HI  = 3'd4;
    localparam logic [IDX_W-1:0] BYTE_VAL_LO  = 3'd5;
    localparam logic [IDX_W-1:0] BYTE_CRC_LO  = 3'd6;
    localparam logic [IDX_W-1:0] BYTE_CRC_HI  = 3'd7;

    typedef struct packed {
        logic [BYTE_W-1:0] slave;
        logic [ADDR_W-1:0] addr;
        logic [VAL_W-1:0]  val;
        logic [15:0]       crc;
    } frame_t;

    typedef struct packed {
        logic [BYTE_W-1:0] slave;
        logic [ADDR_W-1:0] addr;
        logic [PROD_W-1:0] prod;
        logic [VAL_W-1:0]  val;
        logic [15:0]       crc;
    } stage_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [BYTE_W-1:0] b);
        logic [15:0] acc;
        acc = c ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
        end
        return acc;
    endfunction

endpackage

@@ rtl/core/mwrf_pipe.sv @@
// Pipeline: scaling, saturation, CRC-16; stages 1-6 each add one frame byte.
module mwrf_pipe (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [mwrf_pkg::ADDR_W-1:0]   in_addr,
    input  logic [mwrf_pkg::VOLT_W-1:0]   in_volt,
    input  logic [mwrf_pkg::BYTE_W-1:0]   in_slave,
    output logic                          out_valid,
    input  logic                          out_ready,
    output mwrf_pkg::frame_t              out_frame
);
    import mwrf_pkg::*;

    logic   [NSTAGE-1:0] valid_reg;
    logic   [NSTAGE-1:0] adv;
    stage_t              st_reg  [NSTAGE];
    stage_t              st_next [NSTAGE];
    logic   [PROD_W-1:0] whole;

    always_comb
    begin
        adv[NSTAGE-1] = !valid_reg[NSTAGE-1] || out_ready;
        for (int i = NSTAGE - 2; i >= 0; i--)
        begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
    end

    assign in_ready = adv[0];

    always_comb
    begin
        whole = st_reg[1].prod >> VOLTAGE_FRACTION_BITS;

        st_next[0]       = st_reg[0];
        st_next[0].slave = in_slave;
        st_next[0].addr  = in_addr;
        st_next[0].prod  = PROD_W'(in_volt);

        // scale to hundredths, first CRC byte
        st_next[1]      = st_reg[0];
        st_next[1].prod = PROD_W'(st_reg[0].prod[VOLT_W-1:0]) * PROD_W'(SCALE_HUNDREDTHS);
        st_next[1].crc  = crc_byte(CRC_INIT, st_reg[0].slave);

        // drop fraction, saturate
        st_next[2]     = st_reg[1];
        st_next[2].val = (|whole[PROD_W-1:VAL_W]) ? {VAL_W{1'b1}} : whole[VAL_W-1:0];
        st_next[2].crc = crc_byte(st_reg[1].crc, FUNC_WRITE_SINGLE);

        st_next[3]     = st_reg[2];
        st_next[3].crc = crc_byte(st_reg[2].crc, st_reg[2].addr[15:8]);

        st_next[4]     = st_reg[3];
        st_next[4].crc = crc_byte(st_reg[3].crc, st_reg[3].addr[7:0]);

        st_next[5]     = st_reg[4];
        st_next[5].crc = crc_byte(st_reg[4].crc, st_reg[4].val[15:8]);

        st_next[6]     = st_reg[5];
        st_next[6].crc = crc_byte(st_reg[5].crc, st_reg[5].val[7:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int i = 1; i < NSTAGE; i++)
            begin
                if (adv[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NSTAGE; i++)
        begin
            if (adv[i])
            begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    assign out_valid       = valid_reg[NSTAGE-1];
    assign out_frame.slave = st_reg[NSTAGE-1].slave;
    assign out_frame.addr  = st_reg[NSTAGE-1].addr;
    assign out_frame.val   = st_reg[NSTAGE-1].val;
    assign out_frame.crc   = st_reg[NSTAGE-1].crc;

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_frame)))
        else $error("pipeline output changed while stalled");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[NSTAGE-2] && !adv[NSTAGE-1]) |=> valid_reg[NSTAGE-2])
        else $error("stage lost its request while the next stage was full");

endmodule

@@ rtl/core/mwrf_serial.sv @@
// Output serialiser: sends the eight frame bytes in transmit order.
module mwrf_serial (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  mwrf_pkg::frame_t              in_frame,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [mwrf_pkg::BYTE_W-1:0]   out_byte,
    output logic                          out_last
);
    import mwrf_pkg::*;

    logic             busy_reg;
    logic             busy_next;
    logic [IDX_W-1:0] count_reg;
    logic [IDX_W-1:0] count_next;
    frame_t           frame_reg;
    logic             take;
    logic             load;

    assign take      = busy_reg && out_ready;
    assign out_last  = busy_reg && (count_reg == BYTE_CRC_HI);
    assign in_ready  = !busy_reg || (take && count_reg == BYTE_CRC_HI);
    assign load      = in_valid && in_ready;
    assign out_valid = busy_reg;

    always_comb
    begin
        busy_next  = busy_reg;
        count_next = count_reg;
        if (take)
        begin
            count_next = count_reg + 1'b1;
            if (count_reg == BYTE_CRC_HI)
            begin
                busy_next = 1'b0;
            end
        end
        if (load)
        begin
            busy_next  = 1'b1;
            count_next = BYTE_SLAVE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= BYTE_SLAVE;
        end
        else
        begin
            busy_reg  <= busy_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            frame_reg <= in_frame;
        end
    end

    always_comb
    begin
        case (count_reg)
            BYTE_SLAVE:   out_byte = frame_reg.slave;
            BYTE_FUNC:    out_byte = FUNC_WRITE_SINGLE;
            BYTE_ADDR_HI: out_byte = frame_reg.addr[15:8];
            BYTE_ADDR_LO: out_byte = frame_reg.addr[7:0];
            BYTE_VAL_HI:  out_byte = frame_reg.val[15:8];
            BYTE_VAL_LO:  out_byte = frame_reg.val[7:0];
            BYTE_CRC_LO:  out_byte = frame_reg.crc[7:0];
            BYTE_CRC_HI:  out_byte = frame_reg.crc[15:8];
            default:      out_byte = frame_reg.slave;
        endcase
    end

    a_step: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !out_last) |=> (busy_reg && count_reg == $past(count_reg) + 1'b1))
        else $error("byte index did not advance");

    a_load_only_free: assert property (@(posedge clk) disable iff (!rst_n)
        (load && busy_reg) |-> (take && count_reg == BYTE_CRC_HI))
        else $error("frame loaded over one in progress");

    a_new_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (busy_reg && count_reg == BYTE_SLAVE))
        else $error("new frame did not start at its first byte");

endmodule

@@ rtl/core/modbus_write_register_framer_top.sv @@
// A 7-stage pipeline (input register, scaling multiply, saturation, one CRC byte per
// stage after the input register) feeds the byte serialiser, which sends one frame
// byte per cycle while m_axis_tready is high. The serialiser sets the rate: it takes
// the next frame as the last byte leaves.
// Reset (rst_n, asynchronous, active low) empties the pipeline and the serialiser
// and sets the slave address to 1.
module modbus_write_register_framer_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [mwrf_pkg::BYTE_W-1:0]   cfg_wdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [mwrf_pkg::IN_W-1:0]     s_axis_tdata,  // reg_address[15:0], voltage_q8[39:16]
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [mwrf_pkg::BYTE_W-1:0]   m_axis_tdata,  // frame_byte[7:0]
    output logic                          m_axis_tlast
);
    import mwrf_pkg::*;

    logic [BYTE_W-1:0] slave_address_reg;
    logic              pipe_valid;
    logic              pipe_ready;
    frame_t            pipe_frame;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_address_reg <= SLAVE_ADDR_RESET;
        end
        else if (cfg_we)
        begin
            slave_address_reg <= cfg_wdata;
        end
    end

    mwrf_pipe u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_addr   (s_axis_tdata[ADDR_W-1:0]),
        .in_volt   (s_axis_tdata[IN_W-1:ADDR_W]),
        .in_slave  (slave_address_reg),
        .out_valid (pipe_valid),
        .out_ready (pipe_ready),
        .out_frame (pipe_frame)
    );

    mwrf_serial u_serial (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pipe_valid),
        .in_ready  (pipe_ready),
        .in_frame  (pipe_frame),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_byte  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule
